### design/frqg_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths, codes and reset values for the frame rate quality governor.
// No dependencies; imported by frqg_level, the top level and the bench files.
package frqg_pkg;

    localparam int FT_W       = 20;
    localparam int RATE_W     = 18;
    localparam int PRES_W     = 10;
    localparam int LVL_W      = 3;
    localparam int TS_W       = 32;
    localparam int CD_W       = 16;
    localparam int DROP_W     = 32;
    localparam int ACT_W      = 2;
    localparam int CEV_W      = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 18;

    // 256000000 / frame_time_us gives Q10.8 frames per second
    localparam int              NUM_W    = 28;
    localparam logic [NUM_W-1:0] RATE_NUM = 28'd256000000;

    localparam logic [RATE_W-1:0] RATE_MAX       = '1;
    localparam logic [PRES_W-1:0] PRESSURE_FORCE = 10'd800;
    localparam logic [PRES_W-1:0] PRESSURE_AUTO  = 10'd700;
    localparam logic [LVL_W-1:0]  LEVEL_MAX      = 3'd4;

    localparam int AVG_FRAMES_DEF = 32;

    // event codes
    localparam logic [ACT_W-1:0] ACT_FRAME    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_THERMAL  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_PRESSURE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_SET      = 2'd3;

    // critical event codes
    localparam logic [CEV_W-1:0] CEV_NONE    = 2'd0;
    localparam logic [CEV_W-1:0] CEV_ENTER   = 2'd1;
    localparam logic [CEV_W-1:0] CEV_RECOVER = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_AUTO_ADJUST  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_FPS   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WARNING_FPS  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CRITICAL_FPS = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_COOLDOWN_MS  = 3'd4;

    localparam logic [RATE_W-1:0] TARGET_RST   = 18'd15360;
    localparam logic [RATE_W-1:0] WARNING_RST  = 18'd7680;
    localparam logic [RATE_W-1:0] CRITICAL_RST = 18'd5120;
    localparam logic [CD_W-1:0]   COOLDOWN_RST = 16'd2000;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [FT_W-1:0]   frame_time_us;
        logic              throttling;
        logic [PRES_W-1:0] memory_pressure;
        logic [LVL_W-1:0]  requested_level;
        logic [TS_W-1:0]   now_ms;
    } t_in;

    typedef struct packed {
        logic [LVL_W-1:0]  quality_level;
        logic [RATE_W-1:0] current_fps;
        logic [RATE_W-1:0] average_fps;
        logic [RATE_W-1:0] min_fps;
        logic [DROP_W-1:0] dropped_frames;
        logic [CEV_W-1:0]  critical_event;
        logic              level_changed;
    } t_out;

    typedef struct packed {
        logic              auto_adjust;
        logic [RATE_W-1:0] target_fps;
        logic [RATE_W-1:0] warning_fps;
        logic [RATE_W-1:0] critical_fps;
        logic [CD_W-1:0]   cooldown_ms;
    } t_cfg;

    // event handed to the level controller
    typedef struct packed {
        logic              commit;
        logic [ACT_W-1:0]  action;
        logic              throttling;
        logic [PRES_W-1:0] pressure;
        logic [LVL_W-1:0]  req_level;
        logic [TS_W-1:0]   now_ms;
        logic [RATE_W-1:0] avg_rate;
    } t_lvl_cmd;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             changed;
    } t_lvl_res;

endpackage

### design/frqg_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle, registered result.
// Standalone; no package dependency.
module frqg_div #(
    parameter int DIVD_W = 28,
    parameter int DVSR_W = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DVSR_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] r_dq;     // dividend bits out the top, quotient bits in the bottom
    logic [DVSR_W-1:0] r_rem;
    logic [DVSR_W-1:0] r_dvsr;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DVSR_W:0]   trial;
    logic [DVSR_W:0]   diff;
    logic              fits;
    logic [DVSR_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dq[DIVD_W-1]};
        diff  = trial - {1'b0, r_dvsr};
        fits  = (trial >= {1'b0, r_dvsr});
        n_rem = fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DIVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq   <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_dq  <= {r_dq[DIVD_W-2:0], fits};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dq;

endmodule

### design/frqg_level.sv
`timescale 1ns / 1ps
// Quality level controller: level, thermal and pressure state, cooldown timing.
// Depends on frqg_pkg.
module frqg_level (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  frqg_pkg::t_cfg     i_cfg,
    input  frqg_pkg::t_lvl_cmd i_cmd,
    output frqg_pkg::t_lvl_res o_res
);
    import frqg_pkg::*;

    logic [LVL_W-1:0]  r_level;
    logic              r_thermal;
    logic [PRES_W-1:0] r_pres;
    logic [TS_W-1:0]   r_last;

    logic [TS_W-1:0]   elapsed;
    logic              cool_ok;
    logic              want_down;
    logic              want_up;
    logic [LVL_W-1:0]  set_val;
    logic [LVL_W-1:0]  n_level;

    always_comb begin
        elapsed   = i_cmd.now_ms - r_last;
        cool_ok   = (elapsed >= {{(TS_W-CD_W){1'b0}}, i_cfg.cooldown_ms});
        set_val   = (i_cmd.req_level > LEVEL_MAX) ? LEVEL_MAX : i_cmd.req_level;
        want_down = 1'b0;
        want_up   = 1'b0;
        n_level   = r_level;
        case (i_cmd.action)
            ACT_FRAME: begin
                if (i_cfg.auto_adjust && cool_ok) begin
                    if (i_cmd.avg_rate < i_cfg.warning_fps || r_thermal ||
                        r_pres > PRESSURE_AUTO) begin
                        want_down = 1'b1;
                    end else if (i_cmd.avg_rate > i_cfg.target_fps &&
                                 r_level != '0 && !r_thermal) begin
                        want_up = 1'b1;
                    end
                end
            end
            ACT_THERMAL:  want_down = i_cmd.throttling;
            ACT_PRESSURE: want_down = (i_cmd.pressure > PRESSURE_FORCE);
            ACT_SET:      n_level   = set_val;
            default:      n_level   = r_level;
        endcase
        if (want_down && r_level < LEVEL_MAX) begin
            n_level = r_level + 1'b1;
        end else if (want_up) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= '0;
            r_thermal <= 1'b0;
            r_pres    <= '0;
            r_last    <= '0;
        end else if (i_cmd.commit) begin
            r_level <= n_level;
            if (n_level != r_level) begin
                r_last <= i_cmd.now_ms;
            end
            if (i_cmd.action == ACT_THERMAL) begin
                r_thermal <= i_cmd.throttling;
            end
            if (i_cmd.action == ACT_PRESSURE) begin
                r_pres <= i_cmd.pressure;
            end
        end
    end

    assign o_res.level   = n_level;
    assign o_res.changed = (n_level != r_level);

endmodule

### design/frame_rate_quality_governor_top.sv
`timescale 1ns / 1ps
// Frame rate quality governor, top level: handshakes, registers, rate statistics.
// Depends on frqg_pkg, frqg_div and frqg_level.
// Sequence: thermal, pressure and set events go from the transfer straight to the update
// state; a frame report waits on a 28-bit serial divide of the rate, adds the rate to the
// block sum and, on the frame that closes a block, waits again while the same divider forms
// the average. A zero frame time skips the rate divide. One event is in work at a time; the
// next transfer is taken once the result sits in the output register.
// Reset (synchronous, active low) restores register defaults and clears all statistics.
module frame_rate_quality_governor_top #(
    parameter int AVERAGE_FRAMES = frqg_pkg::AVG_FRAMES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  frqg_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output frqg_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_we,
    input  logic [frqg_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [frqg_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import frqg_pkg::*;

    // block sum holds up to AVERAGE_FRAMES full-scale rates
    localparam int SUM_W  = RATE_W + $clog2(AVERAGE_FRAMES);
    localparam int CNT_W  = $clog2(AVERAGE_FRAMES + 1);
    localparam int DIVD_W = (SUM_W > NUM_W) ? SUM_W : NUM_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_RATE   = 5'b00010,   // waiting on the rate divide
        ST_ACCUM  = 5'b00100,   // add the rate to the block sum
        ST_AVG    = 5'b01000,   // waiting on the block average divide
        ST_UPDATE = 5'b10000    // decide and load the output register
    } t_state;

    t_state            r_state;
    t_in               r_item;
    t_cfg              r_cfg;
    logic [RATE_W-1:0] r_rate;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_count;
    logic [RATE_W-1:0] r_avg;
    logic [RATE_W-1:0] r_lowest;
    logic [DROP_W-1:0] r_drop;
    logic              r_crit;
    logic              r_out_valid;
    t_out              r_out;

    // divider hookup
    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [FT_W-1:0]   div_divisor;
    logic              div_done;
    logic [DIVD_W-1:0] div_q;

    logic              in_fire;
    logic              commit;
    logic [SUM_W-1:0]  n_sum;
    logic [CNT_W-1:0]  n_count;
    logic              block_end;
    logic [RATE_W-1:0] q_rate;
    logic [DROP_W-1:0] n_drop;
    logic              crit_is;
    logic [CEV_W-1:0]  crit_ev;
    logic              is_frame;

    t_lvl_cmd          lvl_cmd;
    t_lvl_res          lvl_res;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    // a result loads when the output register is empty or emptying this cycle
    assign commit     = (r_state == ST_UPDATE) && (!r_out_valid || i_out_ready);
    assign is_frame   = (r_item.action == ACT_FRAME);

    always_comb begin
        n_sum     = r_sum + SUM_W'(r_rate);
        n_count   = r_count + 1'b1;
        block_end = (n_count == CNT_W'(AVERAGE_FRAMES));
        // anything above 18 quotient bits saturates
        q_rate    = (|div_q[DIVD_W-1:RATE_W]) ? RATE_MAX : div_q[RATE_W-1:0];
    end

    // rate divide starts straight off the transfer; average divide from the sum
    always_comb begin
        div_start    = 1'b0;
        div_dividend = DIVD_W'(RATE_NUM);
        div_divisor  = i_in_data.frame_time_us;
        if (in_fire && i_in_data.action == ACT_FRAME && i_in_data.frame_time_us != '0) begin
            div_start = 1'b1;
        end else if (r_state == ST_ACCUM && block_end) begin
            div_start    = 1'b1;
            div_dividend = DIVD_W'(n_sum);
            div_divisor  = FT_W'(AVERAGE_FRAMES);
        end
    end

    frqg_div #(
        .DIVD_W (DIVD_W),
        .DVSR_W (FT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // drop count judged on the frame's rate, critical transitions on the updated average
    always_comb begin
        n_drop = r_drop;
        if (r_rate < r_cfg.critical_fps && r_drop != '1) begin
            n_drop = r_drop + 1'b1;
        end
        crit_is = (r_avg < r_cfg.critical_fps);
        if (crit_is && !r_crit) begin
            crit_ev = CEV_ENTER;
        end else if (!crit_is && r_crit) begin
            crit_ev = CEV_RECOVER;
        end else begin
            crit_ev = CEV_NONE;
        end
    end

    always_comb begin
        lvl_cmd.commit     = commit;
        lvl_cmd.action     = r_item.action;
        lvl_cmd.throttling = r_item.throttling;
        lvl_cmd.pressure   = r_item.memory_pressure;
        lvl_cmd.req_level  = r_item.requested_level;
        lvl_cmd.now_ms     = r_item.now_ms;
        lvl_cmd.avg_rate   = r_avg;
    end

    frqg_level u_level (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (lvl_cmd),
        .o_res   (lvl_res)
    );

    // configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.auto_adjust  <= 1'b1;
            r_cfg.target_fps   <= TARGET_RST;
            r_cfg.warning_fps  <= WARNING_RST;
            r_cfg.critical_fps <= CRITICAL_RST;
            r_cfg.cooldown_ms  <= COOLDOWN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_AUTO_ADJUST:  r_cfg.auto_adjust  <= i_cfg_wdata[0];
                CFG_TARGET_FPS:   r_cfg.target_fps   <= i_cfg_wdata[RATE_W-1:0];
                CFG_WARNING_FPS:  r_cfg.warning_fps  <= i_cfg_wdata[RATE_W-1:0];
                CFG_CRITICAL_FPS: r_cfg.critical_fps <= i_cfg_wdata[RATE_W-1:0];
                CFG_COOLDOWN_MS:  r_cfg.cooldown_ms  <= i_cfg_wdata[CD_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rate   <= '0;
            r_sum    <= '0;
            r_count  <= '0;
            r_avg    <= '0;
            r_lowest <= RATE_MAX;
            r_drop   <= '0;
            r_crit   <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        if (i_in_data.action != ACT_FRAME) begin
                            r_state <= ST_UPDATE;
                        end else if (i_in_data.frame_time_us == '0) begin
                            r_rate  <= '0;     // zero frame time reads as zero rate
                            r_state <= ST_ACCUM;
                        end else begin
                            r_state <= ST_RATE;
                        end
                    end
                end
                ST_RATE: begin
                    if (div_done) begin
                        r_rate  <= q_rate;
                        r_state <= ST_ACCUM;
                    end
                end
                ST_ACCUM: begin
                    if (block_end) begin
                        r_sum   <= '0;
                        r_count <= '0;
                        r_state <= ST_AVG;
                    end else begin
                        r_sum   <= n_sum;
                        r_count <= n_count;
                        r_state <= ST_UPDATE;
                    end
                end
                ST_AVG: begin
                    if (div_done) begin
                        r_avg <= div_q[RATE_W-1:0];
                        if (div_q[RATE_W-1:0] < r_lowest) begin
                            r_lowest <= div_q[RATE_W-1:0];
                        end
                        r_state <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (commit) begin
                        if (is_frame) begin
                            r_drop <= n_drop;
                            r_crit <= crit_is;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_item <= i_in_data;
        end
    end

    // output register parts the result from the next event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out.quality_level  <= lvl_res.level;
            r_out.current_fps    <= r_rate;
            r_out.average_fps    <= r_avg;
            r_out.min_fps        <= r_lowest;
            r_out.dropped_frames <= is_frame ? n_drop : r_drop;
            r_out.critical_event <= is_frame ? crit_ev : CEV_NONE;
            r_out.level_changed  <= lvl_res.changed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // divider results only show up while the sequencer waits for them
    a_div_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_RATE || r_state == ST_AVG))
        else $error("divider finished outside a divide wait");

    // one event in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("second transfer accepted while an event is in work");

    // a loaded result is presented on the next cycle
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> o_out_valid)
        else $error("result loaded but not presented");

    // block count never reaches the block length between frames
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACCUM) |=> (r_count < CNT_W'(AVERAGE_FRAMES)))
        else $error("block count overran the block length");

endmodule

### bench/frqg_governor_checker.sv
`timescale 1ns / 1ps
// Checker for the frame rate quality governor: predicts each event report and compares it.
// Depends on frqg_pkg; watches the event, report and register-write channels of the top.
module frqg_governor_checker #(
    parameter int AVERAGE_FRAMES = frqg_pkg::AVG_FRAMES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  frqg_pkg::t_in                       i_in_data,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  frqg_pkg::t_out                      i_out_data,
    input  logic                                i_cfg_we,
    input  logic [frqg_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [frqg_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output int                                  o_pending,
    output int                                  o_fail_count
);
    import frqg_pkg::*;

    t_cfg              regs;
    logic [LVL_W-1:0]  level_q;
    int unsigned       rate_sum;
    int unsigned       frames_in_block;
    logic [RATE_W-1:0] last_rate;
    logic [RATE_W-1:0] block_avg;
    logic [RATE_W-1:0] lowest_avg;
    logic [DROP_W-1:0] drops;
    logic              in_critical;
    logic              thermal_on;
    logic [PRES_W-1:0] pressure_q;
    logic [TS_W-1:0]   changed_at;

    t_out expected_reports[$];
    t_out want;

    function automatic bit set_quality(input logic [LVL_W-1:0] lvl, input logic [TS_W-1:0] ts);
        logic [LVL_W-1:0] clamped;
        clamped = (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl;
        if (clamped == level_q)
            return 1'b0;
        level_q    = clamped;
        changed_at = ts;
        return 1'b1;
    endfunction

    function automatic bit drop_quality(input logic [TS_W-1:0] ts);
        if (level_q >= LEVEL_MAX)
            return 1'b0;
        return set_quality(level_q + 3'd1, ts);
    endfunction

    // advances the governor state by one event and returns its report
    function automatic t_out governor_next(input t_in ev);
        t_out              res;
        int unsigned       quot;
        logic [RATE_W-1:0] rate;
        logic [TS_W-1:0]   elapsed;
        logic              crit_now;
        logic              moved;
        res   = '0;
        moved = 1'b0;
        res.critical_event = CEV_NONE;
        case (ev.action)
            ACT_FRAME: begin
                rate = '0;
                if (ev.frame_time_us != '0) begin
                    quot = 32'(RATE_NUM) / 32'(ev.frame_time_us);
                    rate = (quot > RATE_MAX) ? RATE_MAX : quot[RATE_W-1:0];
                end
                last_rate = rate;
                rate_sum += 32'(rate);
                frames_in_block++;
                if (frames_in_block >= AVERAGE_FRAMES) begin
                    quot            = rate_sum / frames_in_block;
                    block_avg       = quot[RATE_W-1:0];
                    rate_sum        = 0;
                    frames_in_block = 0;
                    if (block_avg < lowest_avg)
                        lowest_avg = block_avg;
                end
                if (rate < regs.critical_fps && drops != '1)
                    drops++;
                crit_now = (block_avg < regs.critical_fps);
                if (crit_now && !in_critical)
                    res.critical_event = CEV_ENTER;
                else if (!crit_now && in_critical)
                    res.critical_event = CEV_RECOVER;
                in_critical = crit_now;
                elapsed = ev.now_ms - changed_at;
                if (regs.auto_adjust && elapsed >= regs.cooldown_ms) begin
                    if (block_avg < regs.warning_fps || thermal_on || pressure_q > PRESSURE_AUTO)
                        moved = drop_quality(ev.now_ms);
                    else if (block_avg > regs.target_fps && level_q != '0 && !thermal_on)
                        moved = set_quality(level_q - 3'd1, ev.now_ms);
                end
            end
            ACT_THERMAL: begin
                thermal_on = ev.throttling;
                if (ev.throttling)
                    moved = drop_quality(ev.now_ms);
            end
            ACT_PRESSURE: begin
                pressure_q = ev.memory_pressure;
                if (ev.memory_pressure > PRESSURE_FORCE)
                    moved = drop_quality(ev.now_ms);
            end
            default: begin
                moved = set_quality(ev.requested_level, ev.now_ms);
            end
        endcase
        res.quality_level  = level_q;
        res.current_fps    = last_rate;
        res.average_fps    = block_avg;
        res.min_fps        = lowest_avg;
        res.dropped_frames = drops;
        res.level_changed  = moved;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs            = '{1'b1, TARGET_RST, WARNING_RST, CRITICAL_RST, COOLDOWN_RST};
            level_q         = '0;
            rate_sum        = 0;
            frames_in_block = 0;
            last_rate       = '0;
            block_avg       = '0;
            lowest_avg      = RATE_MAX;
            drops           = '0;
            in_critical     = 1'b0;
            thermal_on      = 1'b0;
            pressure_q      = '0;
            changed_at      = '0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_AUTO_ADJUST:  regs.auto_adjust  = i_cfg_wdata[0];
                    CFG_TARGET_FPS:   regs.target_fps   = i_cfg_wdata[RATE_W-1:0];
                    CFG_WARNING_FPS:  regs.warning_fps  = i_cfg_wdata[RATE_W-1:0];
                    CFG_CRITICAL_FPS: regs.critical_fps = i_cfg_wdata[RATE_W-1:0];
                    CFG_COOLDOWN_MS:  regs.cooldown_ms  = i_cfg_wdata[CD_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("report transfer with no event outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("quality_level", 32'(want.quality_level),
                                32'(i_out_data.quality_level));
                    check_field("current_fps", 32'(want.current_fps),
                                32'(i_out_data.current_fps));
                    check_field("average_fps", 32'(want.average_fps),
                                32'(i_out_data.average_fps));
                    check_field("min_fps", 32'(want.min_fps), 32'(i_out_data.min_fps));
                    check_field("dropped_frames", want.dropped_frames,
                                i_out_data.dropped_frames);
                    check_field("critical_event", 32'(want.critical_event),
                                32'(i_out_data.critical_event));
                    check_field("level_changed", 32'(want.level_changed),
                                32'(i_out_data.level_changed));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_reports.push_back(governor_next(i_in_data));
        end
        o_pending = expected_reports.size();
    end

endmodule

### bench/tb_frame_rate_quality_governor_top.sv
`timescale 1ns / 1ps
// Testbench top for the frame rate quality governor: clock, reset, event stimulus,
// register writes and verdict. Depends on frqg_pkg, the governor RTL and frqg_governor_checker.
module tb_frame_rate_quality_governor_top;
    import frqg_pkg::*;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in                   in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int pending;
    int fail_count;

    // stimulus knobs shared with the report-side process
    logic no_idle     = 1'b0;   // both sides busy every cycle
    logic hold_req    = 1'b0;   // one long report hold-off, raised once
    logic hold_served = 1'b0;
    int   hold_left   = 0;

    // event timeline and current frame pace for the random part
    logic [TS_W-1:0] clock_ms = '0;
    int unsigned     pace_us  = 16000;

    frame_rate_quality_governor_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    frqg_governor_checker #(
        .AVERAGE_FRAMES (AVG_FRAMES_DEF)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Report side: ready drops on about 35 percent of cycles. Once the stimulus asks,
    // ready is held low while a hold-off counter runs down, so the single result register fills and the
    // event side backs up while valid is still being offered.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_req && !hold_served) begin
            hold_served <= 1'b1;
            hold_left   <= 400;
            out_ready   <= 1'b0;
        end else if (no_idle) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= 35);
        end
    end

    function automatic t_in mk_event(input logic [ACT_W-1:0] act, input logic [FT_W-1:0] ft,
                                     input logic thr, input logic [PRES_W-1:0] pres,
                                     input logic [LVL_W-1:0] lvl, input logic [TS_W-1:0] ts);
        t_in ev;
        ev.action          = act;
        ev.frame_time_us   = ft;
        ev.throttling      = thr;
        ev.memory_pressure = pres;
        ev.requested_level = lvl;
        ev.now_ms          = ts;
        return ev;
    endfunction

    // Random event. Fields an action does not use carry noise. Frame times follow a
    // pace that holds for tens of frames, so block averages settle on one side of a
    // threshold long enough for the level to walk in both directions.
    function automatic t_in random_event();
        t_in         ev;
        int unsigned pick;
        ev.action          = ACT_FRAME;
        ev.frame_time_us   = FT_W'($urandom);
        ev.throttling      = 1'($urandom_range(0, 1));
        ev.memory_pressure = PRES_W'($urandom);
        ev.requested_level = LVL_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            if ($urandom_range(0, 39) == 0) begin
                case ($urandom_range(0, 5))
                    0: pace_us = 12000;
                    1: pace_us = 16000;
                    2: pace_us = 25000;
                    3: pace_us = 40000;
                    4: pace_us = 55000;
                    default: pace_us = 90000;
                endcase
            end
            case ($urandom_range(0, 19))
                // zero frame time and saturated rates
                0: ev.frame_time_us = FT_W'($urandom_range(0, 1100));
                // very slow frames, up to the top of the field
                1: ev.frame_time_us = FT_W'($urandom_range(100000, 1048575));
                default: ev.frame_time_us = FT_W'(pace_us - pace_us / 5
                                            + $urandom_range(0, pace_us * 2 / 5));
            endcase
        end else if (pick < 82) begin
            ev.action     = ACT_THERMAL;
            ev.throttling = ($urandom_range(0, 99) < 30);
        end else if (pick < 91) begin
            ev.action = ACT_PRESSURE;
            case ($urandom_range(0, 4))
                0, 1: ev.memory_pressure = PRES_W'($urandom_range(0, 650));
                2: ev.memory_pressure = PRES_W'($urandom_range(650, 850));
                3: ev.memory_pressure = PRES_W'($urandom_range(790, 810));
                default: ev.memory_pressure = PRES_W'($urandom);   // includes 1001..1023
            endcase
        end else begin
            ev.action = ACT_SET;   // 5..7 saturate to the lowest quality
        end
        // mostly small steps, some past the cooldown, a few jumps anywhere (wrap too)
        case ($urandom_range(0, 39))
            0: clock_ms = $urandom;
            1, 2, 3: clock_ms += $urandom_range(2000, 70000);
            default: clock_ms += $urandom_range(0, 400);
        endcase
        ev.now_ms = clock_ms;
        return ev;
    endfunction

    // One event transfer. Valid is only lowered for an idle cycle, so a back-to-back
    // event never sees valid dropped and raised in the same step.
    task automatic send_event(input t_in ev);
        while (!no_idle && $urandom_range(0, 99) < 35) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Wait until every report is back, plus margin for the longest frame.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (70) @(posedge clk);
    endtask

    // All five registers on consecutive cycles; enable stays high across them.
    task automatic apply_settings(input t_cfg s);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_AUTO_ADJUST;
        cfg_wdata <= {17'd0, s.auto_adjust};
        @(posedge clk);
        cfg_addr  <= CFG_TARGET_FPS;
        cfg_wdata <= s.target_fps;
        @(posedge clk);
        cfg_addr  <= CFG_WARNING_FPS;
        cfg_wdata <= s.warning_fps;
        @(posedge clk);
        cfg_addr  <= CFG_CRITICAL_FPS;
        cfg_wdata <= s.critical_fps;
        @(posedge clk);
        cfg_addr  <= CFG_COOLDOWN_MS;
        cfg_wdata <= {2'd0, s.cooldown_ms};
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input t_cfg s, input int count, input logic quiet,
                             input int hold_at);
        settle();
        apply_settings(s);
        no_idle <= quiet;
        for (int k = 0; k < count; k++) begin
            if (k == hold_at)
                hold_req <= 1'b1;
            send_event(random_event());
        end
    endtask

    initial begin
        t_cfg mix;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on reset settings (cooldown 2000 ms, level 0).
        // zero frame time: rate 0, zero average enters critical, cooldown not yet over
        send_event(mk_event(ACT_FRAME, 20'd0, 1'b0, 10'd0, 3'd0, 32'd0));
        // shortest frame time saturates; zero average steps quality down
        send_event(mk_event(ACT_FRAME, 20'd1, 1'b0, 10'd0, 3'd0, 32'd2500));
        // last saturating frame time and the first one below the cap
        send_event(mk_event(ACT_FRAME, 20'd976, 1'b0, 10'd0, 3'd0, 32'd2600));
        send_event(mk_event(ACT_FRAME, 20'd977, 1'b0, 10'd0, 3'd0, 32'd2700));
        send_event(mk_event(ACT_FRAME, 20'd1000000, 1'b0, 10'd0, 3'd0, 32'd2800));
        send_event(mk_event(ACT_FRAME, 20'hFFFFF, 1'b0, 10'd0, 3'd0, 32'd5000));
        // throttling forces a step with no cooldown
        send_event(mk_event(ACT_THERMAL, 20'd0, 1'b1, 10'd0, 3'd0, 32'd5100));
        send_event(mk_event(ACT_FRAME, 20'd16000, 1'b0, 10'd0, 3'd0, 32'd9000));
        // already at the lowest quality: a further step does nothing
        send_event(mk_event(ACT_THERMAL, 20'd0, 1'b1, 10'd0, 3'd0, 32'd9100));
        send_event(mk_event(ACT_THERMAL, 20'd0, 1'b0, 10'd0, 3'd0, 32'd9200));
        // direct requests: best, same again, above range, saturated again, mid
        send_event(mk_event(ACT_SET, 20'd0, 1'b0, 10'd0, 3'd0, 32'd9300));
        send_event(mk_event(ACT_SET, 20'd0, 1'b0, 10'd0, 3'd0, 32'd9400));
        send_event(mk_event(ACT_SET, 20'd0, 1'b0, 10'd0, 3'd7, 32'd9500));
        send_event(mk_event(ACT_SET, 20'd0, 1'b0, 10'd0, 3'd5, 32'd9600));
        send_event(mk_event(ACT_SET, 20'd0, 1'b0, 10'd0, 3'd2, 32'd9700));
        // pressure: above range, exactly the force limit, one above, one above the auto limit, zero
        send_event(mk_event(ACT_PRESSURE, 20'd0, 1'b0, 10'd1023, 3'd0, 32'd9800));
        send_event(mk_event(ACT_PRESSURE, 20'd0, 1'b0, 10'd800, 3'd0, 32'd9900));
        send_event(mk_event(ACT_PRESSURE, 20'd0, 1'b0, 10'd801, 3'd0, 32'd10000));
        send_event(mk_event(ACT_PRESSURE, 20'd0, 1'b0, 10'd701, 3'd0, 32'd10100));
        send_event(mk_event(ACT_PRESSURE, 20'd0, 1'b0, 10'd0, 3'd0, 32'd10200));
        // cooldown across the timestamp wrap: short elapsed time, then long enough
        send_event(mk_event(ACT_SET, 20'd0, 1'b0, 10'd0, 3'd3, 32'hFFFF_FFF0));
        send_event(mk_event(ACT_FRAME, 20'd20000, 1'b0, 10'd0, 3'd0, 32'h0000_0100));
        send_event(mk_event(ACT_FRAME, 20'd20000, 1'b0, 10'd0, 3'd0, 32'h0000_1000));
        clock_ms = 32'h0000_1000;

        // Reset values written back; the long report hold-off lands in this phase.
        run_phase('{1'b1, TARGET_RST, WARNING_RST, CRITICAL_RST, COOLDOWN_RST},
                  200, 1'b0, 60);
        // All thresholds and the cooldown at zero; no idling on either side.
        run_phase('{1'b1, 18'd0, 18'd0, 18'd0, 16'd0}, 100, 1'b1, -1);
        // Everything at its maximum.
        run_phase('{1'b1, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 16'hFFFF}, 100, 1'b0, -1);
        // Auto-adjust off, random thresholds.
        mix.auto_adjust  = 1'b0;
        mix.target_fps   = RATE_W'($urandom);
        mix.warning_fps  = RATE_W'($urandom);
        mix.critical_fps = RATE_W'($urandom);
        mix.cooldown_ms  = CD_W'($urandom);
        run_phase(mix, 80, 1'b0, -1);
        // Auto-adjust on, thresholds scattered around the usual operating points.
        mix.auto_adjust  = 1'b1;
        mix.target_fps   = RATE_W'($urandom_range(12000, 20000));
        mix.warning_fps  = RATE_W'($urandom_range(6000, 9000));
        mix.critical_fps = RATE_W'($urandom_range(3000, 6000));
        mix.cooldown_ms  = CD_W'($urandom_range(0, 3000));
        run_phase(mix, 150, 1'b0, -1);

        settle();
        if (fail_count == 0)
            $display("tb_frame_rate_quality_governor_top: done, clean");
        else
            $display("tb_frame_rate_quality_governor_top: done, errors");
        $finish;
    end

    // Watchdog: ends the run with errors far beyond the slowest legal run.
    initial begin
        #4000000;
        $display("tb_frame_rate_quality_governor_top: done, errors");
        $finish;
    end

endmodule

### files.f
design/frqg_pkg.sv
design/frqg_div.sv
design/frqg_level.sv
design/frame_rate_quality_governor_top.sv
bench/frqg_governor_checker.sv
bench/tb_frame_rate_quality_governor_top.sv
